@@ design/pqd_pkg.sv @@
// ----------------------------------------------------------------------------
// pqd_pkg
// Shared widths, constants, types and the root step function of the packed
// quaternion decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pqd_pkg;

    localparam int WORD_W   = 32;
    localparam int TAG_W    = 24;
    localparam int COMP_W   = 18;
    localparam int FIELD_W  = 10;
    localparam int STORED   = 3;
    localparam int LANES    = STORED + 1;
    localparam int SQ_W     = 2 * FIELD_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int WREM_W   = SUM_W - 1;
    localparam int RAD_W    = 22;
    localparam int ROOT_W   = 27;
    localparam int REM_W    = ROOT_W + 2;
    localparam int QUO_W    = 18;
    localparam int MAG_W    = QUO_W - 1;
    localparam int RECIP_W  = 28;
    localparam int RECIP_SHIFT = 37;
    localparam int PROD_W   = ROOT_W + RECIP_W;
    localparam int DIFF_W   = QUO_W + FIELD_W;

    localparam int STEPS_PER_STAGE = 3;
    localparam int ROOT_STAGES     = ROOT_W / STEPS_PER_STAGE;

    localparam int ST_DEC        = 0;
    localparam int ST_SUM        = 1;
    localparam int ST_ROOT_FIRST = 2;
    localparam int ST_ROOT_LAST  = ST_ROOT_FIRST + ROOT_STAGES - 1;
    localparam int ST_RECIP      = ST_ROOT_LAST + 1;
    localparam int ST_OUT        = ST_RECIP + 1;
    localparam int N_STAGES      = ST_OUT + 1;

    localparam logic [FIELD_W:0]      FIELD_MAX  = 11'd1023;
    localparam logic [SUM_W-1:0]      REM_LIMIT  = 22'd2093058;
    localparam logic [RECIP_W-1:0]    RECIP      = 28'd134348928;
    localparam logic [DIFF_W-1:0]     CORR_LIMIT = 28'd2046;

    // position of the rebuilt component in the output order
    typedef enum logic [1:0] {
        MISSING_AT_1 = 2'd0,
        MISSING_AT_2 = 2'd1,
        MISSING_AT_3 = 2'd2,
        MISSING_AT_0 = 2'd3
    } sel_t;

    typedef struct packed {
        logic [STORED-1:0] neg;
        sel_t              sel;
        logic [TAG_W-1:0]  tag;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } root_lane_t;

    // restoring square root, STEPS_PER_STAGE result bits per call
    function automatic root_lane_t root_steps(root_lane_t s);
        root_lane_t       r;
        logic [REM_W-1:0] acc;
        logic [REM_W-1:0] trial;
        r = s;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            acc   = {r.rem[REM_W-3:0], r.rad[RAD_W-1:RAD_W-2]};
            trial = {r.root, 2'b01};
            r.rad = {r.rad[RAD_W-3:0], 2'b00};
            if (acc >= trial)
            begin
                r.rem  = acc - trial;
                r.root = {r.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                r.rem  = acc;
                r.root = {r.root[ROOT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

@@ design/pqd_word_if.sv @@
// ----------------------------------------------------------------------------
// pqd_word_if
// Input channel: one packed rotation word and its item index per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pqd_word_if;
    logic                          valid;
    logic                          ready;
    logic [pqd_pkg::WORD_W-1:0]    packed_word;
    logic [pqd_pkg::TAG_W-1:0]     item_index;

    modport source (output valid, output packed_word, output item_index, input ready);
    modport sink   (input valid, input packed_word, input item_index, output ready);
endinterface

@@ design/pqd_quat_if.sv @@
// ----------------------------------------------------------------------------
// pqd_quat_if
// Output channel: four signed Q16 components and the item tag per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pqd_quat_if;
    logic                                valid;
    logic                                ready;
    logic signed [pqd_pkg::COMP_W-1:0]   comp_0;
    logic signed [pqd_pkg::COMP_W-1:0]   comp_1;
    logic signed [pqd_pkg::COMP_W-1:0]   comp_2;
    logic signed [pqd_pkg::COMP_W-1:0]   comp_3;
    logic [pqd_pkg::TAG_W-1:0]           tag_out;

    modport source (output valid, output comp_0, output comp_1, output comp_2,
                    output comp_3, output tag_out, input ready);
    modport sink   (input valid, input comp_0, input comp_1, input comp_2,
                    input comp_3, input tag_out, output ready);
endinterface

@@ design/packed_quaternion_decoder_top.sv @@
// ----------------------------------------------------------------------------
// packed_quaternion_decoder_top
// Decodes a smallest-three packed rotation word into four signed Q16
// quaternion components, with the item index passed along.
//
//   channel      dir   payload
//   rotation     in    packed_word[31:0], item_index[23:0]
//   quaternion   out   comp_0..comp_3 (signed 18b Q16), tag_out[23:0]
//
// one item per cycle sustained while the output is ready
// pipeline depth is set by the 27-bit restoring square root, 3 bits per stage
// each stage holds its item until the next stage frees up, so bubbles close
// reset clears only the stage valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_quaternion_decoder_top (
    input  logic         clk,
    input  logic         rst_n,
    pqd_word_if.sink     rotation,
    pqd_quat_if.source   quaternion
);

    logic [pqd_pkg::N_STAGES-1:0]  valid_reg;
    logic [pqd_pkg::N_STAGES-1:0]  valid_next;
    logic [pqd_pkg::N_STAGES:0]    en;

    pqd_pkg::side_t            side_reg [pqd_pkg::N_STAGES];
    pqd_pkg::side_t            side_next;

    logic [pqd_pkg::SQ_W-1:0]  sq_reg  [pqd_pkg::STORED];
    logic [pqd_pkg::SQ_W-1:0]  sq_next [pqd_pkg::STORED];

    pqd_pkg::root_lane_t       lane_reg  [pqd_pkg::ST_SUM:pqd_pkg::ST_ROOT_LAST][pqd_pkg::LANES];
    pqd_pkg::root_lane_t       lane_next [pqd_pkg::LANES];

    logic [pqd_pkg::SUM_W-1:0]  total;
    logic [pqd_pkg::WREM_W-1:0] w_rem;

    logic [pqd_pkg::QUO_W-1:0]  quo_reg   [pqd_pkg::LANES];
    logic [pqd_pkg::QUO_W-1:0]  quo_next  [pqd_pkg::LANES];
    logic [pqd_pkg::ROOT_W-1:0] root_reg  [pqd_pkg::LANES];

    logic [pqd_pkg::DIFF_W-1:0]        diff  [pqd_pkg::LANES];
    logic signed [pqd_pkg::COMP_W-1:0] value [pqd_pkg::LANES];
    logic signed [pqd_pkg::COMP_W-1:0] comp_reg  [pqd_pkg::LANES];
    logic signed [pqd_pkg::COMP_W-1:0] comp_next [pqd_pkg::LANES];

    // stage flow control
    assign en[pqd_pkg::N_STAGES] = quaternion.ready;

    genvar gi;
    generate
        for (gi = 0; gi < pqd_pkg::N_STAGES; gi++)
        begin : g_en
            assign en[gi] = ~valid_reg[gi] | en[gi+1];
        end
    endgenerate

    assign valid_next = (en[pqd_pkg::N_STAGES-1:0]
                         & {valid_reg[pqd_pkg::N_STAGES-2:0], rotation.valid})
                      | (~en[pqd_pkg::N_STAGES-1:0] & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rotation.ready = en[0];

    // field decode and squares
    generate
        for (gi = 0; gi < pqd_pkg::STORED; gi++)
        begin : g_dec
            logic [pqd_pkg::FIELD_W-1:0] field;
            logic [pqd_pkg::FIELD_W:0]   twice;
            logic [pqd_pkg::FIELD_W:0]   mag;
            logic [pqd_pkg::FIELD_W-1:0] mag_lo;

            assign field  = rotation.packed_word[gi*pqd_pkg::FIELD_W +: pqd_pkg::FIELD_W];
            assign twice  = {field, 1'b0};
            assign mag    = field[pqd_pkg::FIELD_W-1] ? (twice - pqd_pkg::FIELD_MAX)
                                                      : (pqd_pkg::FIELD_MAX - twice);
            assign mag_lo = mag[pqd_pkg::FIELD_W-1:0];
            assign sq_next[gi] = mag_lo * mag_lo;
            assign side_next.neg[gi] = ~field[pqd_pkg::FIELD_W-1];
        end
    endgenerate

    assign side_next.sel = pqd_pkg::sel_t'(rotation.packed_word[pqd_pkg::WORD_W-1 -: 2]);
    assign side_next.tag = rotation.item_index;

    always_ff @(posedge clk)
    begin
        if (en[pqd_pkg::ST_DEC])
        begin
            side_reg[pqd_pkg::ST_DEC] <= side_next;
            sq_reg                    <= sq_next;
        end
    end

    generate
        for (gi = 1; gi < pqd_pkg::N_STAGES; gi++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (en[gi])
                begin
                    side_reg[gi] <= side_reg[gi-1];
                end
            end
        end
    endgenerate

    // sum of squares and root radicands
    always_comb
    begin
        total = pqd_pkg::SUM_W'(sq_reg[0]) + pqd_pkg::SUM_W'(sq_reg[1])
              + pqd_pkg::SUM_W'(sq_reg[2]);
        w_rem = (total >= pqd_pkg::REM_LIMIT) ? '0
              : pqd_pkg::WREM_W'(pqd_pkg::REM_LIMIT - total);
        for (int k = 0; k < pqd_pkg::STORED; k++)
        begin
            lane_next[k].rem  = '0;
            lane_next[k].root = '0;
            lane_next[k].rad  = {1'b0, sq_reg[k], 1'b0};
        end
        lane_next[pqd_pkg::STORED].rem  = '0;
        lane_next[pqd_pkg::STORED].root = '0;
        lane_next[pqd_pkg::STORED].rad  = {w_rem, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en[pqd_pkg::ST_SUM])
        begin
            lane_reg[pqd_pkg::ST_SUM] <= lane_next;
        end
    end

    // square root stages
    generate
        for (gi = pqd_pkg::ST_ROOT_FIRST; gi <= pqd_pkg::ST_ROOT_LAST; gi++)
        begin : g_root
            always_ff @(posedge clk)
            begin
                if (en[gi])
                begin
                    for (int k = 0; k < pqd_pkg::LANES; k++)
                    begin
                        lane_reg[gi][k] <= pqd_pkg::root_steps(lane_reg[gi-1][k]);
                    end
                end
            end
        end
    endgenerate

    // divide by 1023 through the reciprocal, then correct and round
    generate
        for (gi = 0; gi < pqd_pkg::LANES; gi++)
        begin : g_div
            logic [pqd_pkg::PROD_W-1:0] prod;
            logic [pqd_pkg::DIFF_W-1:0] base;
            logic [pqd_pkg::QUO_W-1:0]  quo_fix;
            logic [pqd_pkg::QUO_W-1:0]  half_up;
            logic [pqd_pkg::MAG_W-1:0]  mag;
            logic                       neg;

            assign prod = lane_reg[pqd_pkg::ST_ROOT_LAST][gi].root * pqd_pkg::RECIP;
            assign quo_next[gi] = prod[pqd_pkg::RECIP_SHIFT +: pqd_pkg::QUO_W];

            assign base     = {quo_reg[gi], {pqd_pkg::FIELD_W{1'b0}}}
                            - pqd_pkg::DIFF_W'(quo_reg[gi]);
            assign diff[gi] = pqd_pkg::DIFF_W'(root_reg[gi]) - base;
            assign quo_fix  = quo_reg[gi]
                            + pqd_pkg::QUO_W'(diff[gi] >= pqd_pkg::DIFF_W'(pqd_pkg::FIELD_MAX));
            assign half_up  = quo_fix + pqd_pkg::QUO_W'(1);
            assign mag      = half_up[pqd_pkg::QUO_W-1:1];

            if (gi < pqd_pkg::STORED)
            begin : g_sgn
                assign neg = side_reg[pqd_pkg::ST_RECIP].neg[gi];
            end
            else
            begin : g_pos
                assign neg = 1'b0;
            end

            assign value[gi] = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

            always_ff @(posedge clk)
            begin
                if (en[pqd_pkg::ST_RECIP])
                begin
                    quo_reg[gi]  <= quo_next[gi];
                    root_reg[gi] <= lane_reg[pqd_pkg::ST_ROOT_LAST][gi].root;
                end
            end
        end
    endgenerate

    // output order
    always_comb
    begin
        unique case (side_reg[pqd_pkg::ST_RECIP].sel)
            pqd_pkg::MISSING_AT_1:
            begin
                comp_next[0] = value[2];
                comp_next[1] = value[3];
                comp_next[2] = value[0];
                comp_next[3] = value[1];
            end
            pqd_pkg::MISSING_AT_2:
            begin
                comp_next[0] = value[2];
                comp_next[1] = value[0];
                comp_next[2] = value[3];
                comp_next[3] = value[1];
            end
            pqd_pkg::MISSING_AT_3:
            begin
                comp_next[0] = value[2];
                comp_next[1] = value[0];
                comp_next[2] = value[1];
                comp_next[3] = value[3];
            end
            pqd_pkg::MISSING_AT_0:
            begin
                comp_next[0] = value[3];
                comp_next[1] = value[0];
                comp_next[2] = value[1];
                comp_next[3] = value[2];
            end
            default:
            begin
                comp_next = value;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[pqd_pkg::ST_OUT])
        begin
            comp_reg <= comp_next;
        end
    end

    assign quaternion.valid   = valid_reg[pqd_pkg::ST_OUT];
    assign quaternion.comp_0  = comp_reg[0];
    assign quaternion.comp_1  = comp_reg[1];
    assign quaternion.comp_2  = comp_reg[2];
    assign quaternion.comp_3  = comp_reg[3];
    assign quaternion.tag_out = side_reg[pqd_pkg::ST_OUT].tag;

`ifndef NO_ASSERTIONS
    // input is refused only when every stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !rotation.ready |-> (&valid_reg))
        else $error("input stalled with a free stage");

    // reciprocal estimate for the rebuilt lane is never more than one low
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[pqd_pkg::ST_RECIP] |-> (diff[pqd_pkg::STORED] < pqd_pkg::CORR_LIMIT))
        else $error("quotient correction out of range");

    // rebuilt component is never negative when it sits in output slot 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (quaternion.valid && side_reg[pqd_pkg::ST_OUT].sel == pqd_pkg::MISSING_AT_0)
        |-> !quaternion.comp_0[pqd_pkg::COMP_W-1])
        else $error("negative rebuilt component");

    // an item stalled at the output is still there next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[pqd_pkg::ST_RECIP] && !en[pqd_pkg::ST_RECIP]) |=> valid_reg[pqd_pkg::ST_OUT])
        else $error("item lost behind a stalled output");
`endif

endmodule

@@ tb/tb_packed_quaternion_decoder_top.sv @@
// ----------------------------------------------------------------------------
// tb_packed_quaternion_decoder_top
// Self-checking bench for the packed quaternion decoder. A queue-fed driver
// streams rotation words and a monitor checks every decoded quaternion, in
// order, against a bit-level integer model of the smallest-three decode. The
// four components may differ from the model by at most one LSB and the tag
// must match exactly. Directed corner words come first, then random words
// under several handshake idle patterns and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_packed_quaternion_decoder_top;

    localparam int RANDOM_PER_PHASE = 85;
    localparam int HOLD_ITEMS       = 40;
    localparam int HOLD_CYCLES      = 150;
    localparam int DRAIN_CYCLES     = 30;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [pqd_pkg::WORD_W-1:0] word;
        logic [pqd_pkg::TAG_W-1:0]  tag;
    } rotation_item_t;

    typedef struct {
        logic signed [pqd_pkg::COMP_W-1:0] comp [4];
        logic [pqd_pkg::TAG_W-1:0]         tag;
    } quat_t;

    logic clk = 1'b0;
    logic rst_n;

    pqd_word_if rotation_ch ();
    pqd_quat_if quat_ch ();

    packed_quaternion_decoder_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rotation   (rotation_ch),
        .quaternion (quat_ch)
    );

    rotation_item_t pending_words [$];
    quat_t          expected_quats [$];
    idle_mode_t     idle_mode = IDLE_NONE;
    logic           hold_rx = 1'b0;
    int             words_accepted = 0;
    int             quats_checked = 0;
    int             mismatch_count = 0;

    always #10 clk = ~clk;

    // nearest integer to sqrt(m * 2^31) / 1023
    function automatic int unsigned nearest_scaled_root(longint unsigned m);
        longint unsigned target;
        longint unsigned t;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        target = m << 33;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            t = (longint'(mid) * 2 - 1) * longint'(pqd_pkg::FIELD_MAX);
            if (t * t <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic signed [pqd_pkg::COMP_W-1:0] field_to_q16(
        input  logic [pqd_pkg::FIELD_W-1:0] f,
        output longint unsigned             sq
    );
        int                                a;
        int                                mag;
        logic signed [pqd_pkg::COMP_W-1:0] r;
        a = 2 * int'(f) - int'(pqd_pkg::FIELD_MAX);
        mag = (a < 0) ? -a : a;
        sq = longint'(mag) * longint'(mag);
        r = pqd_pkg::COMP_W'(nearest_scaled_root(sq));
        return (a < 0) ? -r : r;
    endfunction

    function automatic quat_t decode_rotation(logic [pqd_pkg::WORD_W-1:0] word,
                                              logic [pqd_pkg::TAG_W-1:0] tag);
        quat_t                             q;
        longint unsigned                   s0;
        longint unsigned                   s1;
        longint unsigned                   s2;
        longint unsigned                   total;
        longint unsigned                   limit;
        logic signed [pqd_pkg::COMP_W-1:0] qx;
        logic signed [pqd_pkg::COMP_W-1:0] qy;
        logic signed [pqd_pkg::COMP_W-1:0] qz;
        logic signed [pqd_pkg::COMP_W-1:0] qw;
        qx = field_to_q16(word[pqd_pkg::FIELD_W-1:0], s0);
        qy = field_to_q16(word[2*pqd_pkg::FIELD_W-1:pqd_pkg::FIELD_W], s1);
        qz = field_to_q16(word[3*pqd_pkg::FIELD_W-1:2*pqd_pkg::FIELD_W], s2);
        total = s0 + s1 + s2;
        limit = 2 * longint'(pqd_pkg::FIELD_MAX) * longint'(pqd_pkg::FIELD_MAX);
        qw = pqd_pkg::COMP_W'(nearest_scaled_root((total >= limit) ? 0 : limit - total));
        case (pqd_pkg::sel_t'(word[pqd_pkg::WORD_W-1:pqd_pkg::WORD_W-2]))
            pqd_pkg::MISSING_AT_1: q.comp = '{qz, qw, qx, qy};
            pqd_pkg::MISSING_AT_2: q.comp = '{qz, qx, qw, qy};
            pqd_pkg::MISSING_AT_3: q.comp = '{qz, qx, qy, qw};
            default:               q.comp = '{qw, qx, qy, qz};
        endcase
        q.tag = tag;
        return q;
    endfunction

    function automatic logic [pqd_pkg::WORD_W-1:0] pack_rotation(
        pqd_pkg::sel_t               sel,
        logic [pqd_pkg::FIELD_W-1:0] x,
        logic [pqd_pkg::FIELD_W-1:0] y,
        logic [pqd_pkg::FIELD_W-1:0] z
    );
        return {sel, z, y, x};
    endfunction

    function automatic logic [pqd_pkg::FIELD_W-1:0] random_field();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return pqd_pkg::FIELD_W'($urandom_range(512, 511));
            default: return pqd_pkg::FIELD_W'($urandom_range(1023));
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_word(logic [pqd_pkg::WORD_W-1:0] word,
                              logic [pqd_pkg::TAG_W-1:0] tag);
        rotation_item_t it;
        it.word = word;
        it.tag = tag;
        pending_words.insert(pending_words.size(), it);
    endtask

    task automatic queue_random_words(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                queue_word($urandom, pqd_pkg::TAG_W'($urandom));
            else
                queue_word(pack_rotation(pqd_pkg::sel_t'($urandom_range(3)), random_field(),
                                         random_field(), random_field()),
                           pqd_pkg::TAG_W'($urandom));
        end
    endtask

    task automatic wait_for_drain();
        while (pending_words.size() > 0 || rotation_ch.valid || expected_quats.size() > 0)
            @(negedge clk);
    endtask

    function automatic bit roll_idle(bit sender_side);
        int pct;
        case (idle_mode)
            IDLE_SENDER:   pct = sender_side ? 81 : 0;
            IDLE_RECEIVER: pct = sender_side ? 0 : 81;
            IDLE_BOTH:     pct = 19;
            default:       pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        rotation_item_t it;
        if (!rst_n)
        begin
            rotation_ch.valid       <= 1'b0;
            rotation_ch.packed_word <= '0;
            rotation_ch.item_index  <= '0;
        end
        else
        begin
            if (rotation_ch.valid && rotation_ch.ready)
            begin
                expected_quats.insert(expected_quats.size(),
                                      decode_rotation(rotation_ch.packed_word,
                                                      rotation_ch.item_index));
                words_accepted++;
            end
            if (!rotation_ch.valid || rotation_ch.ready)
            begin
                if (pending_words.size() > 0 && !roll_idle(1'b1))
                begin
                    it = pending_words.pop_front();
                    rotation_ch.valid       <= 1'b1;
                    rotation_ch.packed_word <= it.word;
                    rotation_ch.item_index  <= it.tag;
                end
                else
                begin
                    rotation_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        quat_t got;
        quat_t want;
        int    d;
        if (!rst_n)
        begin
            quat_ch.ready <= 1'b0;
        end
        else
        begin
            if (quat_ch.valid && quat_ch.ready)
            begin
                got.comp = '{quat_ch.comp_0, quat_ch.comp_1, quat_ch.comp_2, quat_ch.comp_3};
                got.tag = quat_ch.tag_out;
                if (expected_quats.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, tag %06h", got.tag));
                end
                else
                begin
                    want = expected_quats.pop_front();
                    quats_checked++;
                    for (int i = 0; i < 4; i++)
                    begin
                        d = int'(got.comp[i]) - int'(want.comp[i]);
                        if (d > 1 || d < -1)
                            report_mismatch($sformatf("tag %06h comp_%0d got %0d want %0d",
                                                      want.tag, i, got.comp[i],
                                                      want.comp[i]));
                    end
                    if (got.tag !== want.tag)
                        report_mismatch($sformatf("tag_out got %06h want %06h",
                                                  got.tag, want.tag));
                end
            end
            quat_ch.ready <= !(hold_rx || roll_idle(1'b0));
        end
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d results still pending", expected_quats.size());
        $display("tb_packed_quaternion_decoder_top NOT OK");
        $finish;
    end

    initial
    begin
        pqd_pkg::sel_t sel;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner words: extremes, center codes, saturated missing component
        queue_word(32'h0000_0000, 24'h000000);
        queue_word(32'hFFFF_FFFF, 24'hFFFFFF);
        for (int s = 0; s < 4; s++)
        begin
            sel = pqd_pkg::sel_t'(s);
            queue_word(pack_rotation(sel, 10'd511, 10'd512, 10'd511), 24'h555555);
            queue_word(pack_rotation(sel, 10'd0, 10'd0, 10'd0), 24'hAAAAAA);
            queue_word(pack_rotation(sel, 10'd1023, 10'd1023, 10'd511), 24'h555555);
            queue_word(pack_rotation(sel, 10'd1023, 10'd512, 10'd0), 24'hAAAAAA);
            queue_word(pack_rotation(sel, 10'd300, 10'd700, 10'd100),
                       pqd_pkg::TAG_W'($urandom));
        end
        wait_for_drain();

        // output held off while the sender keeps offering
        hold_rx = 1'b1;
        queue_random_words(HOLD_ITEMS);
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
        wait_for_drain();

        for (int m = 0; m < 4; m++)
        begin
            idle_mode = idle_mode_t'(m);
            queue_random_words(RANDOM_PER_PHASE);
            wait_for_drain();
        end

        idle_mode = IDLE_NONE;
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_quats.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", expected_quats.size()));

        $display("decoded %0d rotation words, checked %0d quaternions", words_accepted,
                 quats_checked);
        $display("all selector codes, corner fields, saturation, gaps, stalls and hold-off");
        if (mismatch_count == 0)
            $display("tb_packed_quaternion_decoder_top OK");
        else
            $display("tb_packed_quaternion_decoder_top NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
design/pqd_pkg.sv
design/pqd_word_if.sv
design/pqd_quat_if.sv
design/packed_quaternion_decoder_top.sv
tb/tb_packed_quaternion_decoder_top.sv
